FILE: sv/rcpd_pkg.sv
// shared types and constants for the rc pulse to h-bridge drive block
// payload structs, configuration struct, register indexes, queue sizing
package rcpd_pkg;

   localparam int TS_BITS     = 32;
   localparam int CMD_BITS    = 9;
   localparam int OFF_BITS    = 10;
   localparam int DUTY_BITS   = 8;
   localparam int JUMP_BITS   = 10;
   localparam int CSR_BITS    = 3;
   localparam int CSR_DBITS   = 10;

   localparam int PULSE_MIN_US = 1000;
   localparam int PULSE_MAX_US = 2000;
   localparam int CMD_TOP      = 511;
   localparam int DUTY_TOP     = 255;

   // reciprocal of 1000 scaled by 2^20, rounded down so the estimate never overshoots
   localparam int RECIP_MUL   = 1048;
   localparam int RECIP_SHIFT = 20;
   localparam int PROD_BITS   = 19;   // offset * 511 fits below 2^19
   localparam int REM_BITS    = 11;

   localparam int QDEPTH     = 4;
   localparam int QPTR_BITS  = $clog2(QDEPTH);
   localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

   localparam logic [CMD_BITS-1:0]  RST_DB_UPPER  = 9'd265;
   localparam logic [CMD_BITS-1:0]  RST_DB_LOWER  = 9'd245;
   localparam logic [CMD_BITS-1:0]  RST_FWD_OFF   = 9'd256;
   localparam logic [CMD_BITS-1:0]  RST_REV_BASE  = 9'd255;
   localparam logic [JUMP_BITS-1:0] RST_JUMP      = 10'd400;
   localparam logic [CMD_BITS-1:0]  RST_LAST_GOOD = 9'd255;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_DB_UPPER  = 3'd0,
      CSR_DB_LOWER  = 3'd1,
      CSR_FWD_OFF   = 3'd2,
      CSR_REV_BASE  = 3'd3,
      CSR_JUMP      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               edge_level;
      logic [TS_BITS-1:0] timestamp_us;
      logic               full_on_mode;
   } req_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] drive_a_duty;
      logic [DUTY_BITS-1:0] drive_b_duty;
      logic                 neutral_led;
      logic [CMD_BITS-1:0]  command_value;
   } rsp_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]  deadband_upper;
      logic [CMD_BITS-1:0]  deadband_lower;
      logic [CMD_BITS-1:0]  forward_offset;
      logic [CMD_BITS-1:0]  reverse_base;
      logic [JUMP_BITS-1:0] jump_limit;
   } cfg_type;

   // clamped pulse width minus 1000 us, plus drive mode
   typedef struct packed {
      logic                full_on;
      logic [OFF_BITS-1:0] offset;
   } qentry_type;

endpackage

FILE: sv/rcpd_front.sv
// front end: accepts edge events, keeps the pulse start time, measures and clamps
// the width of each pulse and pushes it to the queue; uses rcpd_pkg
module rcpd_front
   import rcpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  logic       q_full,
   output logic       q_push,
   output qentry_type q_entry
);

   logic [TS_BITS-1:0] start_ff;
   logic [TS_BITS-1:0] start_in;
   logic [TS_BITS-1:0] width;
   logic               accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && !req_data.edge_level;

   // subtraction wraps modulo the timestamp width
   assign width = req_data.timestamp_us - start_ff;

   always_comb begin
      q_entry.full_on = req_data.full_on_mode;
      if (width < TS_BITS'(PULSE_MIN_US)) begin
         q_entry.offset = '0;
      end else if (width > TS_BITS'(PULSE_MAX_US)) begin
         q_entry.offset = OFF_BITS'(PULSE_MAX_US - PULSE_MIN_US);
      end else begin
         q_entry.offset = OFF_BITS'(width - TS_BITS'(PULSE_MIN_US));
      end
   end

   always_comb begin
      start_in = start_ff;
      if (accept && req_data.edge_level) begin
         start_in = req_data.timestamp_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else begin
         start_ff <= start_in;
      end
   end

endmodule

FILE: sv/rcpd_fifo.sv
// short queue between front and back end, depth from rcpd_pkg
// holds measured pulse offsets and drive mode
module rcpd_fifo
   import rcpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output qentry_type head_data
);

   qentry_type           mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_BITS'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/rcpd_back.sv
// back end: maps pulse offset to a 0..511 command, filters bad commands against the
// last good one and drives the h-bridge duties; uses rcpd_pkg
module rcpd_back
   import rcpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  qentry_type q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int QEST_BITS = PROD_BITS + 11 - RECIP_SHIFT;

   // stage 1: offset * 511
   logic                  s1_v_ff, s1_fo_ff;
   logic [PROD_BITS-1:0]  s1_p_ff, s1_p_in;
   // stage 2: quotient estimate
   logic                  s2_v_ff, s2_fo_ff;
   logic [PROD_BITS-1:0]  s2_p_ff;
   logic [QEST_BITS-1:0]  s2_q_ff, s2_q_in;
   logic [PROD_BITS+10:0] prod;
   // stage 3: corrected command
   logic                  s3_v_ff, s3_fo_ff;
   logic [CMD_BITS-1:0]   s3_cmd_ff, s3_cmd_in;
   logic [PROD_BITS-1:0]  rem;
   // output stage
   logic                  out_v_ff;
   rsp_type               out_ff, out_in;
   logic [CMD_BITS-1:0]   last_ff, last_in;

   logic                  free1, free2, free3, en_out;
   logic [CMD_BITS-1:0]   diff, use_cmd, fwd_d, rev_d;
   logic                  reject;

   assign en_out = !out_v_ff || !rsp_stall;
   assign free3  = !s3_v_ff || en_out;
   assign free2  = !s2_v_ff || free3;
   assign free1  = !s1_v_ff || free2;
   assign q_pop  = free1 && q_valid;

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   assign s1_p_in = (PROD_BITS'(q_data.offset) << CMD_BITS) - PROD_BITS'(q_data.offset);

   assign prod    = (PROD_BITS + 11)'(s1_p_ff) * (PROD_BITS + 11)'(RECIP_MUL);
   assign s2_q_in = prod[PROD_BITS+10:RECIP_SHIFT];

   // estimate is low by at most one
   assign rem       = s2_p_ff - PROD_BITS'(s2_q_ff) * PROD_BITS'(PULSE_MAX_US - PULSE_MIN_US);
   assign s3_cmd_in = CMD_BITS'(s2_q_ff)
                      + CMD_BITS'(rem >= PROD_BITS'(PULSE_MAX_US - PULSE_MIN_US));

   always_comb begin
      diff    = (s3_cmd_ff > last_ff) ? (s3_cmd_ff - last_ff) : (last_ff - s3_cmd_ff);
      reject  = (s3_cmd_ff == '0) || (s3_cmd_ff == CMD_BITS'(CMD_TOP))
                || ({1'b0, diff, 1'b0} > {1'b0, cfg.jump_limit});
      use_cmd = reject ? last_ff : s3_cmd_ff;
      last_in = last_ff;
      if (en_out && s3_v_ff && !reject) begin
         last_in = s3_cmd_ff;
      end

      fwd_d = use_cmd - cfg.forward_offset;
      rev_d = cfg.reverse_base - use_cmd;

      out_in               = '0;
      out_in.command_value = use_cmd;
      if (use_cmd > cfg.deadband_upper) begin
         if (s3_fo_ff) begin
            out_in.drive_a_duty = DUTY_BITS'(DUTY_TOP);
         end else if (use_cmd <= cfg.forward_offset) begin
            out_in.drive_a_duty = '0;
         end else if (fwd_d > CMD_BITS'(DUTY_TOP)) begin
            out_in.drive_a_duty = DUTY_BITS'(DUTY_TOP);
         end else begin
            out_in.drive_a_duty = fwd_d[DUTY_BITS-1:0];
         end
      end else if (use_cmd < cfg.deadband_lower) begin
         if (s3_fo_ff) begin
            out_in.drive_b_duty = DUTY_BITS'(DUTY_TOP);
         end else if (cfg.reverse_base <= use_cmd) begin
            out_in.drive_b_duty = '0;
         end else if (rev_d > CMD_BITS'(DUTY_TOP)) begin
            out_in.drive_b_duty = DUTY_BITS'(DUTY_TOP);
         end else begin
            out_in.drive_b_duty = rev_d[DUTY_BITS-1:0];
         end
      end else begin
         out_in.neutral_led = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         last_ff  <= RST_LAST_GOOD;
      end else begin
         if (free1) begin
            s1_v_ff <= q_valid;
         end
         if (free2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (free3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en_out) begin
            out_v_ff <= s3_v_ff;
         end
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         s1_p_ff  <= s1_p_in;
         s1_fo_ff <= q_data.full_on;
      end
      if (free2) begin
         s2_p_ff  <= s1_p_ff;
         s2_q_ff  <= s2_q_in;
         s2_fo_ff <= s1_fo_ff;
      end
      if (free3) begin
         s3_cmd_ff <= s3_cmd_in;
         s3_fo_ff  <= s2_fo_ff;
      end
      if (en_out && s3_v_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: sv/rc_pulse_to_hbridge_drive_core.sv
// a falling edge's result passes the queue, then each back-end stage in turn; rsp_stall can hold it
// throughput: one edge per cycle; rising edges give no result, a full 4-entry queue stalls input
// the back end runs a four-stage pipe (multiply, reciprocal estimate, correction, filter/drive)
// reset (synchronous): queue and pipe empty, registers at defaults, start time 0,
// last good command 255
module rc_pulse_to_hbridge_drive_core
   import rcpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [CSR_DBITS-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_push, q_full, q_pop, q_not_empty;
   qentry_type q_in_data, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DB_UPPER: cfg_in.deadband_upper = csr_wdata[CMD_BITS-1:0];
            CSR_DB_LOWER: cfg_in.deadband_lower = csr_wdata[CMD_BITS-1:0];
            CSR_FWD_OFF:  cfg_in.forward_offset = csr_wdata[CMD_BITS-1:0];
            CSR_REV_BASE: cfg_in.reverse_base   = csr_wdata[CMD_BITS-1:0];
            CSR_JUMP:     cfg_in.jump_limit     = csr_wdata[JUMP_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_upper <= RST_DB_UPPER;
         cfg_ff.deadband_lower <= RST_DB_LOWER;
         cfg_ff.forward_offset <= RST_FWD_OFF;
         cfg_ff.reverse_base   <= RST_REV_BASE;
         cfg_ff.jump_limit     <= RST_JUMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in_data)
   );

   rcpd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   rcpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_not_empty),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // stopped motor drives neither side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.neutral_led |->
         rsp_data.drive_a_duty == '0 && rsp_data.drive_b_duty == '0)
      else $error("neutral result with nonzero duty");

   // never both half-bridges on at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive_a_duty == '0 || rsp_data.drive_b_duty == '0)
      else $error("both half-bridges driven");

   // rejected end values never become the command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.command_value != '0
                    && rsp_data.command_value != CMD_BITS'(CMD_TOP))
      else $error("end-of-range command accepted");

   // queue never pops when empty
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule

FILE: test/rc_pulse_to_hbridge_drive_core_tb.sv
// testbench for rc_pulse_to_hbridge_drive_core: edge stimulus, register phases, drive scoreboard
// depends on rcpd_pkg and the core; the scoreboard predicts each falling edge's drive update
module rc_pulse_to_hbridge_drive_core_tb;
   import rcpd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_EDGES     = 128;
   localparam int PHASE_COUNT     = 8;

   // predicts drive updates and holds them until the core delivers them
   class drive_scoreboard;
      logic [CMD_BITS-1:0]  db_upper;
      logic [CMD_BITS-1:0]  db_lower;
      logic [CMD_BITS-1:0]  fwd_offset;
      logic [CMD_BITS-1:0]  rev_base;
      logic [JUMP_BITS-1:0] jump_limit;
      logic [TS_BITS-1:0]   start_time;
      logic [CMD_BITS-1:0]  last_good;
      rsp_type              drive_q[$];
      int                   errors;
      int                   checked;
      int                   held;
      int                   reg_writes;

      function new();
         db_upper   = RST_DB_UPPER;
         db_lower   = RST_DB_LOWER;
         fwd_offset = RST_FWD_OFF;
         rev_base   = RST_REV_BASE;
         jump_limit = RST_JUMP;
         start_time = '0;
         last_good  = RST_LAST_GOOD;
         errors     = 0;
         checked    = 0;
         held       = 0;
         reg_writes = 0;
      endfunction

      function int pending();
         return drive_q.size();
      endfunction

      function void set_register(logic [CSR_BITS-1:0] idx, logic [CSR_DBITS-1:0] value);
         reg_writes++;
         case (csr_index_type'(idx))
            CSR_DB_UPPER: db_upper   = value[CMD_BITS-1:0];
            CSR_DB_LOWER: db_lower   = value[CMD_BITS-1:0];
            CSR_FWD_OFF:  fwd_offset = value[CMD_BITS-1:0];
            CSR_REV_BASE: rev_base   = value[CMD_BITS-1:0];
            CSR_JUMP:     jump_limit = value[JUMP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [DUTY_BITS-1:0] clip_duty(int v);
         if (v < 0) return '0;
         if (v > DUTY_TOP) return DUTY_BITS'(DUTY_TOP);
         return DUTY_BITS'(v);
      endfunction

      function void note_request(req_type r);
         logic [TS_BITS-1:0] width;
         int      w;
         int      cmd;
         int      lg;
         int      diff;
         rsp_type drive;
         if (r.edge_level) begin
            start_time = r.timestamp_us;
            return;
         end
         width = r.timestamp_us - start_time;
         if (width < PULSE_MIN_US) w = PULSE_MIN_US;
         else if (width > PULSE_MAX_US) w = PULSE_MAX_US;
         else w = int'(width);
         cmd = (w - PULSE_MIN_US) * CMD_TOP / (PULSE_MAX_US - PULSE_MIN_US);
         lg = int'(last_good);
         diff = (cmd > lg) ? cmd - lg : lg - cmd;
         // endpoints and big jumps fall back to the last good command
         if (cmd == 0 || cmd == CMD_TOP || 2 * diff > int'(jump_limit)) begin
            cmd = lg;
            held++;
         end else begin
            last_good = CMD_BITS'(cmd);
         end
         drive = '0;
         // forward test wins when the deadband registers cross
         if (cmd > int'(db_upper))
            drive.drive_a_duty = r.full_on_mode ? DUTY_BITS'(DUTY_TOP)
                                                : clip_duty(cmd - int'(fwd_offset));
         else if (cmd < int'(db_lower))
            drive.drive_b_duty = r.full_on_mode ? DUTY_BITS'(DUTY_TOP)
                                                : clip_duty(int'(rev_base) - cmd);
         else
            drive.neutral_led = 1'b1;
         drive.command_value = CMD_BITS'(cmd);
         drive_q.push_back(drive);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (drive_q.size() == 0) begin
            report("drive update with no pending falling edge");
            return;
         end
         want = drive_q.pop_front();
         checked++;
         if (got.drive_a_duty !== want.drive_a_duty)
            report($sformatf("drive_a_duty got %0d want %0d",
                             got.drive_a_duty, want.drive_a_duty));
         if (got.drive_b_duty !== want.drive_b_duty)
            report($sformatf("drive_b_duty got %0d want %0d",
                             got.drive_b_duty, want.drive_b_duty));
         if (got.neutral_led !== want.neutral_led)
            report($sformatf("neutral_led got %0d want %0d",
                             got.neutral_led, want.neutral_led));
         if (got.command_value !== want.command_value)
            report($sformatf("command_value got %0d want %0d",
                             got.command_value, want.command_value));
      endtask
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_BITS-1:0]  csr_index = CSR_DB_UPPER;
   logic [CSR_DBITS-1:0] csr_wdata = '0;

   drive_scoreboard sb;
   bit              gaps_on = 1'b1;
   int              edges_sent = 0;
   int              quiet_cycles = 0;

   rc_pulse_to_hbridge_drive_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (csr_we) sb.set_register(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_edge(input logic level, input logic [TS_BITS-1:0] ts,
                            input logic full);
      if (gaps_on && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{edge_level: level, timestamp_us: ts, full_on_mode: full};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      edges_sent++;
   endtask

   task automatic send_pulse(input logic [TS_BITS-1:0] base, input logic [TS_BITS-1:0] width,
                             input logic full);
      send_edge(1'b1, base, full);
      send_edge(1'b0, base + width, full);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DBITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [CSR_DBITS-1:0] up, input logic [CSR_DBITS-1:0] lo,
                               input logic [CSR_DBITS-1:0] fwd, input logic [CSR_DBITS-1:0] rev,
                               input logic [CSR_DBITS-1:0] jmp);
      wait_drained();
      write_csr(CSR_DB_UPPER, up);
      write_csr(CSR_DB_LOWER, lo);
      write_csr(CSR_FWD_OFF, fwd);
      write_csr(CSR_REV_BASE, rev);
      write_csr(CSR_JUMP, jmp);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly clean pulses steered near the last good command, plus noise
   task automatic send_random_edge();
      int   kind;
      int   span;
      int   target;
      int   width;
      logic full;
      logic [TS_BITS-1:0] base;
      kind = $urandom_range(0, 99);
      full = ($urandom_range(0, 3) == 0);
      base = $urandom;
      if (kind < 70) begin
         span   = int'(sb.jump_limit) / 2 + 8;
         target = int'(sb.last_good) + int'($urandom_range(0, 2 * span)) - span;
         if (target < 1) target = 1;
         if (target > CMD_TOP - 1) target = CMD_TOP - 1;
         width = PULSE_MIN_US + (target * 1000 + 510) / 511 + int'($urandom_range(0, 1));
         send_pulse(base, TS_BITS'(width), full);
      end else if (kind < 82) begin
         send_pulse(base, TS_BITS'($urandom_range(900, 2100)), full);
      end else if (kind < 88) begin
         send_edge(1'b0, base, full);
      end else if (kind < 93) begin
         send_edge(1'b1, base, full);
      end else begin
         // wrapped or huge widths
         send_pulse(base, $urandom, full);
      end
   endtask

   initial begin
      int p;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers
      send_edge(1'b0, 32'd1500, 1'b0);                   // falling edge with no rising edge
      send_edge(1'b1, 32'hFFFF_FF00, 1'b0);              // width across the timestamp wrap
      send_edge(1'b0, 32'h0000_0400, 1'b0);
      send_pulse($urandom, 32'd500, 1'b0);               // short pulse clamps to zero
      send_pulse($urandom, 32'd2500, 1'b0);              // long pulse clamps to top
      send_edge(1'b1, 32'd100, 1'b0);                    // falling before rising: huge width
      send_edge(1'b0, 32'd50, 1'b1);
      send_pulse($urandom, 32'd1600, 1'b0);
      send_pulse($urandom, 32'd1998, 1'b0);              // jump too large
      send_pulse($urandom, 32'd1800, 1'b0);
      send_pulse($urandom, 32'd1998, 1'b1);
      send_pulse($urandom, 32'd1500, 1'b0);
      send_pulse($urandom, 32'd1300, 1'b1);
      send_pulse($urandom, 32'd1100, 1'b0);
      send_pulse($urandom, 32'd1002, 1'b0);
      send_edge(1'b1, 32'hFFFF_FFFF, 1'b1);
      send_edge(1'b0, 32'h0000_0000, 1'b1);

      for (p = 0; p < PHASE_COUNT; p++) begin
         gaps_on = 1'b1;
         case (p)
            0: apply_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
            1: apply_config(10'd511, 10'd511, 10'd511, 10'd511, 10'd1023);
            2: apply_config(10'd200, 10'd300, 10'd100, 10'd400, 10'd400);   // crossed deadband
            3: apply_config(10'd265, 10'd245, 10'd256, 10'd255, 10'd400);
            4: apply_config(CSR_DBITS'(256 + $urandom_range(0, 60)),
                            CSR_DBITS'(256 - $urandom_range(0, 60)),
                            CSR_DBITS'(200 + $urandom_range(0, 100)),
                            CSR_DBITS'(200 + $urandom_range(0, 100)),
                            CSR_DBITS'($urandom_range(100, 1023)));
            default: apply_config(CSR_DBITS'($urandom_range(0, 1023)),
                                  CSR_DBITS'($urandom_range(0, 1023)),
                                  CSR_DBITS'($urandom_range(0, 1023)),
                                  CSR_DBITS'($urandom_range(0, 1023)),
                                  CSR_DBITS'($urandom_range(0, 1023)));
         endcase
         // one phase runs back to back with no idle cycles on either side
         if (p == 3) gaps_on = 1'b0;
         repeat (PHASE_EDGES / 2) send_random_edge();
         if (p == 5) wait_drained();
         repeat (PHASE_EDGES / 2) send_random_edge();
      end

      gaps_on = 1'b0;
      wait_drained();
      $display("run covered %0d edges and %0d drive updates (%0d held on last good command)",
               edges_sent, sb.checked, sb.held);
      $display("%0d register writes across %0d register phases", sb.reg_writes, PHASE_COUNT);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/rcpd_pkg.sv
sv/rcpd_front.sv
sv/rcpd_fifo.sv
sv/rcpd_back.sv
sv/rc_pulse_to_hbridge_drive_core.sv
test/rc_pulse_to_hbridge_drive_core_tb.sv
